// ----- rtl/core/sacksb_pkg.sv -----
// ----------------------------------------------------------------------------
// sacksb_pkg
// Shared types and constants of the SACK retransmit scoreboard.
// ----------------------------------------------------------------------------
`default_nettype none

package sacksb_pkg;

	localparam int DEF_TABLE_DEPTH = 64;

	typedef enum logic [2:0] {
		MODE_INIT    = 3'd0,
		MODE_ENQ     = 3'd1,
		MODE_DISCARD = 3'd2,
		MODE_SET_SK  = 3'd3,
		MODE_CLR_SK  = 3'd4,
		MODE_CLR_RS  = 3'd5,
		MODE_QUERY   = 3'd6,
		MODE_NOP     = 3'd7
	} mode_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK,
		ST_FIN,
		ST_OUT
	} state_t;

	localparam logic [1:0] STATUS_OK        = 2'd0;
	localparam logic [1:0] STATUS_FULL      = 2'd1;
	localparam logic [1:0] STATUS_NOT_FOUND = 2'd2;

	typedef struct packed {
		logic [31:0] start;
		logic [31:0] stop;
		logic        sacked;
		logic        resent;
	} entry_t;

	function automatic logic seq_le(input logic [31:0] a, input logic [31:0] b);
		logic [31:0] d;
		d = b - a;
		return ~d[31];
	endfunction

	function automatic logic seq_lt(input logic [31:0] a, input logic [31:0] b);
		return (a != b) && seq_le(a, b);
	endfunction

endpackage

`default_nettype wire

// ----- rtl/core/sacksb_ram.sv -----
// ----------------------------------------------------------------------------
// sacksb_ram
// Region table storage: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module sacksb_ram
	import sacksb_pkg::*;
#(
	parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
	parameter int AW          = $clog2(TABLE_DEPTH)
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire entry_t        wdata,
	input  wire logic [AW-1:0] raddr,
	output entry_t             rdata
);

	entry_t mem [TABLE_DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// ----- rtl/core/sack_retransmit_scoreboard.sv -----
// ----------------------------------------------------------------------------
// sack_retransmit_scoreboard
// Ordered table of sent sequence regions with sacked and resent marks.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_stall) carries one command word: mode, seq_from,
// seq_to. Output channel (out_valid/out_stall) returns one result word per
// command with status, query results, totals, region count and window.
// Every command walks all held regions once through the table memory, one
// region per cycle behind a registered read, then the finish state applies
// the push or window update. One command is in flight at a time, so a new
// word is taken only once the result word has left.
// in_stall stays high while a command is being worked and while the result
// word waits; a stalled result word holds its value.
// Reset clears the region count, head pointer and window; table contents are
// not cleared and are only read for held regions.
// ----------------------------------------------------------------------------
`default_nettype none

module sack_retransmit_scoreboard
	import sacksb_pkg::*;
#(
	parameter int TABLE_DEPTH = DEF_TABLE_DEPTH
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [2:0]  mode,
	input  wire logic [31:0] seq_from,
	input  wire logic [31:0] seq_to,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [1:0]       status,
	output logic             region_sacked,
	output logic [31:0]      sacked_bytes_after,
	output logic [6:0]       sack_blocks_after,
	output logic [31:0]      marked_run_bytes,
	output logic [31:0]      total_sacked_bytes,
	output logic [31:0]      highest_sacked_end,
	output logic [31:0]      highest_resent_end,
	output logic [6:0]       region_count,
	output logic [31:0]      window_first,
	output logic [31:0]      window_last
);

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int CW = $clog2(TABLE_DEPTH + 1);

	function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] a);
		return (a == AW'(TABLE_DEPTH - 1)) ? '0 : a + AW'(1);
	endfunction

	state_t state_q, state_d;

	logic [AW-1:0] head_q;
	logic [CW-1:0] held_q;
	logic [31:0]   wl_q, wh_q;

	mode_t         mode_q;
	logic [31:0]   from_q, to_q;

	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] rd_cnt_q;
	logic          p_vld_s1;
	logic [AW-1:0] p_addr_s1;

	logic          found_q, in_run_q;
	logic          rs_found_q, rs_val_q;
	logic [31:0]   sb_q, run_q, tot_q, hs_q, hr_q;
	logic [CW-1:0] blk_q;
	logic          past_k_q, prev_sk_q;
	logic [31:0]   prev_stop_q;
	logic          run_started_q, run_done_q;
	logic [CW-1:0] kept_q;
	logic [AW-1:0] wr_ptr_q, new_head_q;
	logic [31:0]   first_start_q, last_stop_q;

	logic          rd_issue;
	entry_t        rdata, wdata;
	logic          we;
	logic [AW-1:0] waddr;

	assign in_stall = (state_q != ST_IDLE);
	assign out_valid = (state_q == ST_OUT);
	assign rd_issue = (state_q == ST_WALK) && (rd_cnt_q != held_q);

	sacksb_ram #(
		.TABLE_DEPTH(TABLE_DEPTH),
		.AW(AW)
	) u_ram (
		.clk(clk),
		.we(we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(rd_ptr_q),
		.rdata(rdata)
	);

	// per-entry processing
	logic [31:0] len;
	logic        nsk, nrs, e_we, keep, counted;
	logic        enq_en, qen, ren, inrange, cur_act, set_m;
	logic [AW-1:0] e_waddr;

	assign len = rdata.stop - rdata.start;
	assign enq_en = seq_le(wl_q, from_q) && seq_le(to_q, wh_q);
	assign qen = (held_q != '0) && !seq_le(wh_q, from_q);
	assign ren = (from_q != '0) && (held_q != '0) && seq_le(wl_q, from_q) &&
		seq_le(from_q, wh_q);
	assign inrange = past_k_q || !seq_lt(rdata.start, from_q);
	assign cur_act = !run_done_q &&
		(run_started_q ? (rdata.start == prev_stop_q) : (rdata.start == from_q));
	assign keep = !seq_lt(rdata.start, from_q);
	assign set_m = seq_le(to_q, wh_q) && seq_le(rdata.stop, to_q) &&
		(in_run_q || (rdata.start == from_q));

	always_comb begin
		nsk = rdata.sacked;
		nrs = rdata.resent;
		e_we = 1'b0;
		e_waddr = p_addr_s1;
		counted = 1'b1;
		case (mode_q)
			MODE_ENQ: begin
				if (enq_en && rdata.start == from_q && rdata.stop == to_q) begin
					nrs = 1'b1;
					e_we = 1'b1;
				end
			end
			MODE_DISCARD: begin
				counted = keep;
				e_we = keep;
				e_waddr = (kept_q != '0) ? wr_ptr_q : p_addr_s1;
			end
			MODE_SET_SK: begin
				if (set_m) begin
					nsk = 1'b1;
					e_we = 1'b1;
				end
			end
			MODE_CLR_SK: begin
				nsk = 1'b0;
				e_we = 1'b1;
			end
			MODE_CLR_RS: begin
				nrs = 1'b0;
				e_we = 1'b1;
			end
			default: begin
			end
		endcase
	end

	// finish-cycle updates
	logic          push_en;
	logic [AW-1:0] push_addr;
	logic [CW:0]   push_sum;
	logic [1:0]    status_d;
	logic [AW-1:0] head_d;
	logic [CW-1:0] held_d;
	logic [31:0]   wl_d, wh_d;

	assign push_sum = {1'b0, held_q} + (CW+1)'(head_q);
	assign push_addr = (push_sum >= (CW+1)'(TABLE_DEPTH)) ?
		AW'(push_sum - (CW+1)'(TABLE_DEPTH)) : AW'(push_sum);

	always_comb begin
		push_en = 1'b0;
		status_d = STATUS_OK;
		head_d = head_q;
		held_d = held_q;
		wl_d = wl_q;
		wh_d = wh_q;
		case (mode_q)
			MODE_INIT: begin
				wl_d = from_q;
				wh_d = from_q;
			end
			MODE_ENQ: begin
				if (held_q == '0) begin
					wl_d = from_q;
					wh_d = to_q;
					push_en = 1'b1;
				end else if (!found_q) begin
					if (held_q < CW'(TABLE_DEPTH)) begin
						push_en = 1'b1;
						wh_d = to_q;
					end else begin
						status_d = STATUS_FULL;
					end
				end
			end
			MODE_DISCARD: begin
				if (held_q != '0) begin
					held_d = kept_q;
					if (kept_q == '0) begin
						head_d = ptr_inc(p_addr_s1);
						wl_d = '0;
						wh_d = '0;
					end else begin
						head_d = new_head_q;
						wl_d = first_start_q;
						wh_d = last_stop_q;
					end
				end
			end
			MODE_SET_SK: begin
				if (!found_q) begin
					status_d = STATUS_NOT_FOUND;
				end
			end
			default: begin
			end
		endcase
		if (push_en) begin
			held_d = held_q + CW'(1);
		end
	end

	always_comb begin
		we = 1'b0;
		waddr = e_waddr;
		wdata = '{start: rdata.start, stop: rdata.stop, sacked: nsk, resent: nrs};
		if (state_q == ST_WALK && p_vld_s1) begin
			we = e_we;
		end else if (state_q == ST_FIN) begin
			we = push_en;
			waddr = push_addr;
			wdata = '{start: from_q, stop: to_q, sacked: 1'b0, resent: 1'b0};
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (in_valid) state_d = ST_WALK;
			ST_WALK: if (!rd_issue && !p_vld_s1) state_d = ST_FIN;
			ST_FIN:  state_d = ST_OUT;
			ST_OUT:  if (!out_stall) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			head_q <= '0;
			held_q <= '0;
			wl_q <= '0;
			wh_q <= '0;
			p_vld_s1 <= 1'b0;
		end else begin
			state_q <= state_d;
			p_vld_s1 <= rd_issue;
			if (state_q == ST_FIN) begin
				head_q <= head_d;
				held_q <= held_d;
				wl_q <= wl_d;
				wh_q <= wh_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) begin
			mode_q <= mode_t'(mode);
			from_q <= seq_from;
			to_q <= seq_to;
			rd_ptr_q <= head_q;
			rd_cnt_q <= '0;
			found_q <= 1'b0;
			in_run_q <= 1'b0;
			rs_found_q <= 1'b0;
			rs_val_q <= 1'b0;
			sb_q <= '0;
			blk_q <= '0;
			run_q <= '0;
			tot_q <= '0;
			hs_q <= '0;
			hr_q <= '0;
			past_k_q <= 1'b0;
			prev_sk_q <= 1'b0;
			prev_stop_q <= '0;
			run_started_q <= 1'b0;
			run_done_q <= 1'b0;
			kept_q <= '0;
		end
		if (rd_issue) begin
			rd_ptr_q <= ptr_inc(rd_ptr_q);
			rd_cnt_q <= rd_cnt_q + CW'(1);
			p_addr_s1 <= rd_ptr_q;
		end
		if (state_q == ST_WALK && p_vld_s1) begin
			if (e_we && mode_q != MODE_DISCARD) found_q <= 1'b1;
			in_run_q <= set_m;
			if (counted) begin
				if (nsk) begin
					tot_q <= tot_q + len;
					hs_q <= rdata.stop;
				end
				if (nrs) hr_q <= rdata.stop;
			end
			if (mode_q == MODE_DISCARD && keep) begin
				if (kept_q == '0) begin
					new_head_q <= p_addr_s1;
					first_start_q <= rdata.start;
				end
				wr_ptr_q <= ptr_inc(e_waddr);
				kept_q <= kept_q + CW'(1);
				last_stop_q <= rdata.stop;
			end
			if (mode_q == MODE_QUERY) begin
				if (seq_le(wl_q, from_q) && !rs_found_q && rdata.start == from_q) begin
					rs_found_q <= 1'b1;
					rs_val_q <= rdata.sacked;
				end
				if (qen && inrange && rdata.sacked) begin
					sb_q <= sb_q + len;
					if (!(prev_sk_q && rdata.start == prev_stop_q))
						blk_q <= blk_q + CW'(1);
				end
				if (ren && cur_act && (rdata.sacked || rdata.resent))
					run_q <= run_q + len;
				past_k_q <= inrange;
				prev_sk_q <= inrange && rdata.sacked;
				run_started_q <= run_started_q || (rdata.start == from_q);
				run_done_q <= run_done_q ||
					(run_started_q && rdata.start != prev_stop_q) ||
					(cur_act && !(rdata.sacked || rdata.resent));
			end
			prev_stop_q <= rdata.stop;
		end
		if (state_q == ST_FIN) begin
			status <= status_d;
			region_sacked <= rs_val_q;
			sacked_bytes_after <= sb_q;
			sack_blocks_after <= 7'(blk_q);
			marked_run_bytes <= run_q;
			total_sacked_bytes <= tot_q;
			highest_sacked_end <= hs_q;
			highest_resent_end <= hr_q;
			region_count <= 7'(held_d);
			window_first <= wl_d;
			window_last <= wh_d;
		end
	end

`ifndef ASSERT_OFF
	a_held_bound: assert property (@(posedge clk) disable iff (!arst_n)
		held_q <= CW'(TABLE_DEPTH))
		else $error("region count beyond table depth");
	a_one_word: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("input taken while result word pending");
	a_walk_read: assert property (@(posedge clk) disable iff (!arst_n)
		p_vld_s1 |-> state_q == ST_WALK)
		else $error("table read outside walk");
	a_walk_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_WALK |-> rd_cnt_q <= held_q)
		else $error("walk past table end");
`endif

endmodule

`default_nettype wire
